// ===== hw/rtl/atbeh_pkg.sv =====
// Shared types and constants for the time-binned event histogram.
package atbeh_pkg;

    localparam int TW = 32;

    // Command codes of an input word
    localparam logic [2:0] CMD_CREATE  = 3'd0;
    localparam logic [2:0] CMD_BEGIN   = 3'd1;
    localparam logic [2:0] CMD_END     = 3'd2;
    localparam logic [2:0] CMD_READ    = 3'd3;
    localparam logic [2:0] CMD_RESTART = 3'd4;

    // Message kinds
    localparam logic [2:0] KIND_GROUP          = 3'd2;
    localparam logic [2:0] KIND_QUIESCE_BCAST  = 3'd5;

    // Counter rows
    localparam int ROW_BUSY   = 0;
    localparam int ROW_CREATE = 1;
    localparam int ROW_PROC   = 4;

    // Configuration register indexes
    localparam logic [1:0] CFG_INIT_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_TRACE_START = 2'd1;
    localparam logic [1:0] CFG_SYS_ENTRY   = 2'd2;

    localparam logic [30:0] RESET_WIDTH = 31'd1000;

    typedef struct packed {
        logic [2:0]  command;
        logic [31:0] event_time;
        logic [2:0]  msg_kind;
        logic [15:0] entry_point;
        logic [2:0]  read_row;
        logic [7:0]  read_bin;
    } t_in_word;

    typedef struct packed {
        logic [31:0] read_value;
        logic [7:0]  bins_in_use;
        logic [31:0] width_now;
        logic        in_execution;
    } t_out_word;

    typedef enum logic [4:0] {
        S_BOOT_CLR, S_IDLE, S_DECODE, S_DIVT_GO, S_DIVT_WAIT, S_CHECK0,
        S_DIVS_GO, S_DIVS_WAIT, S_CHECK, S_FOLD_INIT, S_FOLD_RD0, S_FOLD_RD1,
        S_FOLD_WR, S_FOLD_ZERO, S_FOLD_END, S_PLACE, S_BEGIN, S_BUSY_MUL,
        S_BUSY_BASE, S_BUSY_RD, S_BUSY_WR, S_CNT_RD, S_CNT_WR, S_END,
        S_READ_RD, S_READ_LATCH, S_RCLR, S_DONE
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE, OP_CLR_WR, OP_CAPTURE, OP_RESTART, OP_DIVT_GO, OP_DIVT_WAIT,
        OP_DIVS_GO, OP_DIVS_WAIT, OP_FOLD_INIT, OP_FOLD_RD0, OP_FOLD_RD1,
        OP_FOLD_WR, OP_FOLD_ZERO, OP_FOLD_END, OP_PLACE, OP_BEGIN, OP_BUSY_MUL,
        OP_BUSY_BASE, OP_BUSY_RD, OP_BUSY_WR, OP_CNT_RD, OP_CNT_WR, OP_END,
        OP_READ_RD, OP_READ_LATCH, OP_EMIT
    } t_op;

    typedef struct packed {
        t_op  op;
        logic in_ready;
    } t_ctl;

    typedef struct packed {
        logic [2:0] cmd;
        logic       in_take;
        logic       kind_ok;
        logic       sys_skip;
        logic       exec;
        logic       div_done;
        logic       q_ge;
        logic       w_top;
        logic       pair_last;
        logic       l_last;
        logic       row_last;
        logic       busy_more;
        logic       out_free;
    } t_sts;

endpackage

// ===== hw/rtl/atbeh_stream_if.sv =====
// Valid/ready channel carrying one word of a given payload type.
interface atbeh_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/atbeh_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module atbeh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1792
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hw/rtl/atbeh_div.sv =====
// Restoring 32-bit unsigned divider, one quotient bit per cycle.
module atbeh_div
    import atbeh_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [TW-1:0] i_dividend,
    input  logic [TW-1:0] i_divisor,
    output logic          o_done,
    output logic [TW-1:0] o_quotient
);
    logic [5:0]    r_cnt;
    logic          r_done;
    logic [TW-1:0] r_rem, r_quo, r_dvs;
    logic [TW:0]   shifted, diff;

    assign shifted = {r_rem, r_quo[TW-1]};
    assign diff    = shifted - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= 6'(TW);
            end else if (r_cnt != '0) begin
                r_cnt  <= r_cnt - 6'd1;
                r_done <= (r_cnt == 6'd1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_cnt != '0) begin
            if (!diff[TW]) begin
                r_rem <= diff[TW-1:0];
                r_quo <= {r_quo[TW-2:0], 1'b1};
            end else begin
                r_rem <= shifted[TW-1:0];
                r_quo <= {r_quo[TW-2:0], 1'b0};
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;
endmodule

// ===== hw/rtl/atbeh_ctrl.sv =====
// Sequencer: steps each command through the datapath micro-operations.
module atbeh_ctrl
    import atbeh_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_sts i_sts,
    output t_ctl o_ctl
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_BOOT_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_BOOT_CLR, S_RCLR: begin
                if (i_sts.l_last && i_sts.row_last) begin
                    n_state = (r_state == S_RCLR) ? S_DONE : S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_sts.in_take) n_state = S_DECODE;
            end
            S_DECODE: begin
                case (i_sts.cmd)
                    CMD_CREATE:  n_state = S_DIVT_GO;
                    CMD_BEGIN:   n_state = i_sts.sys_skip ? S_DONE : S_DIVT_GO;
                    CMD_END:     n_state = i_sts.exec ? S_DIVT_GO : S_DONE;
                    CMD_READ:    n_state = S_READ_RD;
                    CMD_RESTART: n_state = S_RCLR;
                    default:     n_state = S_DONE;
                endcase
            end
            S_DIVT_GO:   n_state = S_DIVT_WAIT;
            S_DIVT_WAIT: begin
                if (i_sts.div_done) n_state = S_CHECK0;
            end
            S_CHECK0: begin
                n_state = (i_sts.q_ge && !i_sts.w_top && i_sts.exec) ? S_DIVS_GO : S_CHECK;
            end
            S_DIVS_GO:   n_state = S_DIVS_WAIT;
            S_DIVS_WAIT: begin
                if (i_sts.div_done) n_state = S_CHECK;
            end
            S_CHECK: begin
                n_state = (i_sts.q_ge && !i_sts.w_top) ? S_FOLD_INIT : S_PLACE;
            end
            S_FOLD_INIT: n_state = S_FOLD_RD0;
            S_FOLD_RD0:  n_state = S_FOLD_RD1;
            S_FOLD_RD1:  n_state = S_FOLD_WR;
            S_FOLD_WR:   n_state = i_sts.pair_last ? S_FOLD_ZERO : S_FOLD_RD0;
            S_FOLD_ZERO: begin
                if (i_sts.l_last) begin
                    n_state = i_sts.row_last ? S_FOLD_END : S_FOLD_RD0;
                end
            end
            S_FOLD_END:  n_state = S_CHECK;
            S_PLACE: begin
                case (i_sts.cmd)
                    CMD_CREATE: n_state = i_sts.kind_ok ? S_CNT_RD : S_DONE;
                    CMD_BEGIN:  n_state = S_BEGIN;
                    CMD_END:    n_state = S_BUSY_MUL;
                    default:    n_state = S_DONE;
                endcase
            end
            S_BEGIN:     n_state = S_DONE;
            S_BUSY_MUL:  n_state = S_BUSY_BASE;
            S_BUSY_BASE: n_state = S_BUSY_RD;
            S_BUSY_RD:   n_state = S_BUSY_WR;
            S_BUSY_WR: begin
                if (i_sts.busy_more) n_state = S_BUSY_RD;
                else n_state = i_sts.kind_ok ? S_CNT_RD : S_END;
            end
            S_CNT_RD:    n_state = S_CNT_WR;
            S_CNT_WR:    n_state = (i_sts.cmd == CMD_END) ? S_END : S_DONE;
            S_END:       n_state = S_DONE;
            S_READ_RD:   n_state = S_READ_LATCH;
            S_READ_LATCH: n_state = S_DONE;
            S_DONE: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default:     n_state = S_BOOT_CLR;
        endcase
    end

    always_comb begin
        o_ctl.in_ready = (r_state == S_IDLE);
        case (r_state)
            S_BOOT_CLR, S_RCLR: o_ctl.op = OP_CLR_WR;
            S_IDLE:       o_ctl.op = i_sts.in_take ? OP_CAPTURE : OP_NONE;
            S_DECODE:     o_ctl.op = (i_sts.cmd == CMD_RESTART) ? OP_RESTART : OP_NONE;
            S_DIVT_GO:    o_ctl.op = OP_DIVT_GO;
            S_DIVT_WAIT:  o_ctl.op = OP_DIVT_WAIT;
            S_DIVS_GO:    o_ctl.op = OP_DIVS_GO;
            S_DIVS_WAIT:  o_ctl.op = OP_DIVS_WAIT;
            S_FOLD_INIT:  o_ctl.op = OP_FOLD_INIT;
            S_FOLD_RD0:   o_ctl.op = OP_FOLD_RD0;
            S_FOLD_RD1:   o_ctl.op = OP_FOLD_RD1;
            S_FOLD_WR:    o_ctl.op = OP_FOLD_WR;
            S_FOLD_ZERO:  o_ctl.op = OP_FOLD_ZERO;
            S_FOLD_END:   o_ctl.op = OP_FOLD_END;
            S_PLACE:      o_ctl.op = OP_PLACE;
            S_BEGIN:      o_ctl.op = OP_BEGIN;
            S_BUSY_MUL:   o_ctl.op = OP_BUSY_MUL;
            S_BUSY_BASE:  o_ctl.op = OP_BUSY_BASE;
            S_BUSY_RD:    o_ctl.op = OP_BUSY_RD;
            S_BUSY_WR:    o_ctl.op = OP_BUSY_WR;
            S_CNT_RD:     o_ctl.op = OP_CNT_RD;
            S_CNT_WR:     o_ctl.op = OP_CNT_WR;
            S_END:        o_ctl.op = OP_END;
            S_READ_RD:    o_ctl.op = OP_READ_RD;
            S_READ_LATCH: o_ctl.op = OP_READ_LATCH;
            S_DONE:       o_ctl.op = i_sts.out_free ? OP_EMIT : OP_NONE;
            default:      o_ctl.op = OP_NONE;
        endcase
    end
endmodule

// ===== hw/rtl/atbeh_dp.sv =====
// Datapath: state registers, counter RAM, divider and result register.
module atbeh_dp
    import atbeh_pkg::*;
#(
    parameter int BINS = 256,
    parameter int ROWS = 7
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    input  t_in_word    i_word,
    input  logic        i_out_ready,
    output logic        o_out_valid,
    output t_out_word   o_word,
    input  t_ctl        i_ctl,
    output t_sts        o_sts
);
    localparam int BW    = $clog2(BINS);
    localparam int RW    = $clog2(ROWS);
    localparam int DEPTH = ROWS * BINS;
    localparam int AW    = $clog2(DEPTH);
    localparam int HALF  = (BINS + 1) / 2;
    localparam bit ODD   = (BINS % 2) == 1;

    // configuration
    logic [30:0] r_init_w;
    logic [31:0] r_trace;
    logic [15:0] r_sys;
    // histogram state
    logic [31:0]   r_width, r_stamp;
    logic [BW-1:0] r_cur, r_sbin;
    logic          r_exec;
    // sweep counters
    logic [RW-1:0] r_row;
    logic [BW-1:0] r_l;
    // captured word and scratch
    logic [2:0]  r_cmd, r_kind, r_row_in;
    logic [31:0] r_t, r_q, r_sq, r_acc, r_border, r_begin, r_val;
    logic [15:0] r_ep;
    logic [7:0]  r_bin_in;
    logic        r_out_valid;
    t_out_word   r_out;

    logic          div_start, div_done;
    logic [31:0]   div_num, div_quo;
    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [31:0]   ram_wdata, ram_rdata;
    logic          pair_last, l_last, busy_more, kind_ok, read_ok;
    logic [BW-1:0] busy_bin;
    logic [31:0]   sq_half;

    function automatic logic [AW-1:0] f_addr(input logic [RW-1:0] row,
                                             input logic [BW-1:0] bin);
        return AW'(AW'(row) * AW'(BINS) + AW'(bin));
    endfunction

    assign pair_last = (r_l == BW'(HALF - 1));
    assign l_last    = (r_l == BW'(BINS - 1));
    assign busy_more = (r_l < r_cur);
    assign busy_bin  = busy_more ? r_l : r_cur;
    assign kind_ok   = (r_kind <= KIND_GROUP);
    assign read_ok   = (32'(r_row_in) < 32'(ROWS)) && (32'(r_bin_in) < 32'(BINS));
    assign sq_half   = r_sq >> 1;

    assign o_sts.cmd       = r_cmd;
    assign o_sts.in_take   = i_in_valid && i_ctl.in_ready;
    assign o_sts.kind_ok   = kind_ok;
    assign o_sts.sys_skip  = (r_kind inside {[KIND_GROUP:KIND_QUIESCE_BCAST]})
                             && (r_ep < r_sys);
    assign o_sts.exec      = r_exec;
    assign o_sts.div_done  = div_done;
    assign o_sts.q_ge      = (r_q >= 32'(BINS));
    assign o_sts.w_top     = r_width[31];
    assign o_sts.pair_last = pair_last;
    assign o_sts.l_last    = l_last;
    assign o_sts.row_last  = (r_row == RW'(ROWS - 1));
    assign o_sts.busy_more = busy_more;
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    always_comb begin
        div_start = 1'b0;
        div_num   = r_t - r_trace;
        case (i_ctl.op)
            OP_DIVT_GO: div_start = 1'b1;
            OP_DIVS_GO: begin
                div_start = 1'b1;
                div_num   = r_stamp - r_trace;
            end
            default: ;
        endcase
    end

    atbeh_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_num),
        .i_divisor  (r_width),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // counter RAM address and write data
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = f_addr(r_row, r_l);
        ram_wdata = '0;
        ram_raddr = f_addr(r_row, r_l);
        case (i_ctl.op)
            OP_CLR_WR, OP_FOLD_ZERO: ram_we = 1'b1;
            OP_FOLD_RD0: ram_raddr = f_addr(r_row, BW'(r_l << 1));
            OP_FOLD_RD1: ram_raddr = f_addr(r_row, BW'((r_l << 1) | BW'(1)));
            OP_FOLD_WR: begin
                ram_we    = 1'b1;
                ram_wdata = r_acc + ((ODD && pair_last) ? 32'd0 : ram_rdata);
            end
            OP_BUSY_RD: ram_raddr = f_addr(RW'(ROW_BUSY), busy_bin);
            OP_BUSY_WR: begin
                ram_we    = 1'b1;
                ram_waddr = f_addr(RW'(ROW_BUSY), busy_bin);
                ram_wdata = ram_rdata + (busy_more ? (r_border - r_begin) : (r_t - r_begin));
            end
            OP_CNT_RD, OP_CNT_WR: begin
                if (r_cmd == CMD_END) begin
                    ram_raddr = f_addr(RW'(ROW_PROC) + RW'(r_kind), r_sbin);
                end else begin
                    ram_raddr = f_addr(RW'(ROW_CREATE) + RW'(r_kind), r_cur);
                end
                ram_waddr = ram_raddr;
                ram_we    = (i_ctl.op == OP_CNT_WR);
                ram_wdata = ram_rdata + 32'd1;
            end
            OP_READ_RD: begin
                ram_raddr = read_ok ? f_addr(RW'(r_row_in), BW'(r_bin_in)) : '0;
            end
            default: ;
        endcase
    end

    atbeh_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_w    <= RESET_WIDTH;
            r_trace     <= '0;
            r_sys       <= '0;
            r_width     <= 32'(RESET_WIDTH);
            r_stamp     <= '0;
            r_cur       <= '0;
            r_sbin      <= '0;
            r_exec      <= 1'b0;
            r_row       <= '0;
            r_l         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_INIT_WIDTH:  r_init_w <= i_cfg_data[30:0];
                    CFG_TRACE_START: r_trace  <= i_cfg_data;
                    CFG_SYS_ENTRY:   r_sys    <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            case (i_ctl.op)
                OP_CLR_WR, OP_FOLD_ZERO: begin
                    if (l_last) begin
                        r_l   <= '0;
                        r_row <= r_row + RW'(1);
                    end else begin
                        r_l <= r_l + BW'(1);
                    end
                end
                OP_RESTART: begin
                    r_width <= (r_init_w != '0) ? 32'(r_init_w) : 32'd1;
                    r_cur   <= '0;
                    r_sbin  <= '0;
                    r_stamp <= '0;
                    r_exec  <= 1'b0;
                    r_row   <= '0;
                    r_l     <= '0;
                end
                OP_FOLD_INIT: begin
                    r_row <= '0;
                    r_l   <= '0;
                end
                OP_FOLD_WR: r_l <= r_l + BW'(1);
                OP_FOLD_END: begin
                    r_width <= r_width << 1;
                    if (r_exec) begin
                        r_sbin <= (sq_half >= 32'(BINS)) ? BW'(BINS - 1) : sq_half[BW-1:0];
                    end
                end
                OP_PLACE: r_cur <= (r_q >= 32'(BINS)) ? BW'(BINS - 1) : r_q[BW-1:0];
                OP_BEGIN: begin
                    r_stamp <= r_t;
                    r_sbin  <= r_cur;
                    r_exec  <= 1'b1;
                end
                OP_BUSY_MUL: r_l <= r_sbin;
                OP_BUSY_WR: begin
                    if (busy_more) r_l <= r_l + BW'(1);
                end
                OP_END: begin
                    r_exec  <= 1'b0;
                    r_sbin  <= '0;
                    r_stamp <= '0;
                end
                default: ;
            endcase
            if (i_ctl.op == OP_EMIT) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_ctl.op)
            OP_CAPTURE: begin
                r_cmd    <= i_word.command;
                r_t      <= i_word.event_time;
                r_kind   <= i_word.msg_kind;
                r_ep     <= i_word.entry_point;
                r_row_in <= i_word.read_row;
                r_bin_in <= i_word.read_bin;
                r_val    <= '0;
            end
            OP_DIVT_WAIT: begin
                if (div_done) r_q <= div_quo;
            end
            OP_DIVS_WAIT: begin
                if (div_done) r_sq <= div_quo;
            end
            OP_FOLD_RD1: r_acc <= ram_rdata;
            OP_FOLD_END: begin
                r_q  <= r_q >> 1;
                r_sq <= sq_half;
            end
            OP_BUSY_MUL: begin
                r_border <= r_width * (32'(r_sbin) + 32'd1);
                r_begin  <= r_stamp;
            end
            OP_BUSY_BASE: r_border <= r_border + r_trace;
            OP_BUSY_WR: begin
                if (busy_more) begin
                    r_begin  <= r_border;
                    r_border <= r_border + r_width;
                end
            end
            OP_READ_LATCH: r_val <= read_ok ? ram_rdata : 32'd0;
            OP_EMIT: begin
                r_out.read_value   <= r_val;
                r_out.bins_in_use  <= 8'(r_cur);
                r_out.width_now    <= r_width;
                r_out.in_execution <= r_exec;
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_word      = r_out;
endmodule

// ===== hw/rtl/adaptive_time_binned_event_histogram_top.sv =====
// Top level of the time-binned event histogram: sequencer plus datapath.
//
//  channel   dir  handshake        word
//  i_in      in   valid / ready    t_in_word  (command, time, kind, entry, row, bin)
//  o_out     out  valid / ready    t_out_word (value, bin index, width, executing)
//  cfg       in   i_cfg_we only    index i_cfg_idx, data i_cfg_data
//
// One word at a time. The shift-subtract divider that turns a timestamp into
// a bin index sets most of a word's cost. An end adds a read-modify-write
// per bin spanned on the single RAM port pair, and each width doubling adds a
// fold pass over all ROWS rows. Reset and restart each sweep the counter RAM
// to zero, one entry a cycle, all ROWS*BINS entries (1792 by default); no word
// is taken meanwhile. The result sits in an output register, so a new word is
// taken while the last result still waits on o_out.ready.
module adaptive_time_binned_event_histogram_top
    import atbeh_pkg::*;
#(
    parameter int BINS = 256,
    parameter int ROWS = 7
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    atbeh_stream_if.sink   i_in,
    atbeh_stream_if.source o_out
);
    t_ctl      ctl;
    t_sts      sts;
    logic      out_valid;
    t_out_word out_word;

    atbeh_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_ctl   (ctl)
    );

    atbeh_dp #(.BINS(BINS), .ROWS(ROWS)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in.valid),
        .i_word      (i_in.data),
        .i_out_ready (o_out.ready),
        .o_out_valid (out_valid),
        .o_word      (out_word),
        .i_ctl       (ctl),
        .o_sts       (sts)
    );

    assign i_in.ready  = ctl.in_ready;
    assign o_out.valid = out_valid;
    assign o_out.data  = out_word;
endmodule

// ===== tb/atbeh_checker.sv =====
// Checker for the event histogram: predicts each result word and compares it.
`timescale 1ns / 100ps
module atbeh_checker
    import atbeh_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  t_in_word    i_in_data,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  t_out_word   i_out_data,
    output int          o_errors,
    output int          o_results
);

    localparam int NBINS = 256;
    localparam int NROWS = 7;

    // register copies
    logic [31:0] init_width;
    logic [31:0] trace_start;
    logic [15:0] sys_entries;

    // histogram state
    logic [31:0] hist [NROWS][NBINS];
    logic [31:0] width;
    logic [31:0] cur_bin;
    logic [31:0] beg_bin;
    logic [31:0] beg_stamp;
    logic        busy;

    t_out_word   pending_words [$];

    function automatic logic [31:0] bin_index(logic [31:0] t);
        logic [31:0] w;
        w = (width != 0) ? width : 32'd1;
        return (t - trace_start) / w;
    endfunction

    function automatic void fold_table();
        for (int r = 0; r < NROWS; r++) begin
            for (int l = 0; l < NBINS / 2; l++)
                hist[r][l] = hist[r][2*l] + hist[r][2*l+1];
            for (int j = NBINS / 2; j < NBINS; j++)
                hist[r][j] = '0;
        end
    endfunction

    function automatic void locate(logic [31:0] t);
        logic [31:0] idx;
        logic [31:0] s;
        idx = bin_index(t);
        while (idx >= NBINS) begin
            if (width >= 32'h8000_0000) begin
                idx = NBINS - 1;
                break;
            end
            fold_table();
            width = width * 2;
            idx = bin_index(t);
            if (busy) begin
                s = bin_index(beg_stamp);
                beg_bin = (s >= NBINS) ? NBINS - 1 : s;
            end
        end
        cur_bin = idx;
    endfunction

    function automatic void spread_busy(logic [31:0] t_end);
        logic [31:0] sb;
        logic [31:0] from;
        logic [31:0] border;
        sb = (beg_bin >= NBINS) ? NBINS - 1 : beg_bin;
        from = beg_stamp;
        border = from;
        if (cur_bin > sb) begin
            for (logic [31:0] i = sb; i < cur_bin; i++) begin
                border = width * (i + 1) + trace_start;
                hist[ROW_BUSY][i] = hist[ROW_BUSY][i] + (border - from);
                from = border;
            end
            hist[ROW_BUSY][cur_bin] = hist[ROW_BUSY][cur_bin] + (t_end - border);
        end else begin
            hist[ROW_BUSY][cur_bin] = hist[ROW_BUSY][cur_bin] + (t_end - from);
        end
    endfunction

    function automatic void clear_table();
        for (int r = 0; r < NROWS; r++)
            for (int b = 0; b < NBINS; b++)
                hist[r][b] = '0;
        cur_bin = '0;
        beg_bin = '0;
        beg_stamp = '0;
        busy = 1'b0;
    endfunction

    function automatic t_out_word histogram_step(t_in_word w);
        t_out_word res;
        logic [31:0] value;
        logic [31:0] sb;
        value = '0;
        case (w.command)
            CMD_CREATE: begin
                locate(w.event_time);
                if (w.msg_kind <= KIND_GROUP)
                    hist[ROW_CREATE + w.msg_kind][cur_bin] =
                        hist[ROW_CREATE + w.msg_kind][cur_bin] + 1;
            end
            CMD_BEGIN: begin
                // system entries of group kinds are dropped entirely
                if (!(w.msg_kind >= KIND_GROUP && w.msg_kind <= KIND_QUIESCE_BCAST &&
                      w.entry_point < sys_entries)) begin
                    locate(w.event_time);
                    beg_stamp = w.event_time;
                    beg_bin = cur_bin;
                    busy = 1'b1;
                end
            end
            CMD_END: begin
                if (busy) begin
                    locate(w.event_time);
                    spread_busy(w.event_time);
                    if (w.msg_kind <= KIND_GROUP) begin
                        sb = (beg_bin >= NBINS) ? NBINS - 1 : beg_bin;
                        hist[ROW_PROC + w.msg_kind][sb] = hist[ROW_PROC + w.msg_kind][sb] + 1;
                    end
                    busy = 1'b0;
                    beg_bin = '0;
                    beg_stamp = '0;
                end
            end
            CMD_READ: begin
                if (w.read_row < NROWS)
                    value = hist[w.read_row][w.read_bin];
            end
            CMD_RESTART: begin
                clear_table();
                width = (init_width != 0) ? init_width : 32'd1;
            end
            default: ;
        endcase
        res.read_value   = value;
        res.bins_in_use  = cur_bin[7:0];
        res.width_now    = width;
        res.in_execution = busy;
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH %s: got %h want %h (word %0d)", what, got, want, o_results);
        o_errors++;
    endtask

    initial begin
        o_errors = 0;
        o_results = 0;
        init_width = {1'b0, RESET_WIDTH};
        trace_start = '0;
        sys_entries = '0;
        clear_table();
        width = {1'b0, RESET_WIDTH};
    end

    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n) begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_INIT_WIDTH:  init_width = {1'b0, i_cfg_data[30:0]};
                    CFG_TRACE_START: trace_start = i_cfg_data;
                    CFG_SYS_ENTRY:   sys_entries = i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                pending_words.push_back(histogram_step(i_in_data));
            if (i_out_valid && i_out_ready) begin
                if (pending_words.size() == 0) begin
                    report_mismatch("unexpected word", '0, '0);
                end else begin
                    want = pending_words.pop_front();
                    if (i_out_data.read_value !== want.read_value)
                        report_mismatch("read_value", i_out_data.read_value, want.read_value);
                    if (i_out_data.bins_in_use !== want.bins_in_use)
                        report_mismatch("bins_in_use", i_out_data.bins_in_use, want.bins_in_use);
                    if (i_out_data.width_now !== want.width_now)
                        report_mismatch("width_now", i_out_data.width_now, want.width_now);
                    if (i_out_data.in_execution !== want.in_execution)
                        report_mismatch("in_execution", i_out_data.in_execution,
                                        want.in_execution);
                end
                o_results++;
            end
        end
    end

endmodule

// ===== tb/tb.sv =====
// Testbench top: drives commands and configuration, and gives the verdict.
`timescale 1ns / 100ps
module tb;
    import atbeh_pkg::*;

    // generous: covers the worst case for folds, stalls and clears with a fourfold margin
    localparam int CYCLE_LIMIT = 8_000_000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [31:0] i_cfg_data;

    atbeh_stream_if #(.T(t_in_word))  in_ch ();
    atbeh_stream_if #(.T(t_out_word)) out_ch ();

    int errors;
    int results;
    int words_sent;
    int cycles;
    int send_idle_pct;   // chance per cycle that the sender holds off
    int recv_stall_pct;  // chance per cycle that the receiver stalls
    logic [31:0] now_t;  // running timestamp of the well-formed traffic
    logic [31:0] step_t; // typical advance per word, matched to the bin width

    adaptive_time_binned_event_histogram_top u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    atbeh_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (in_ch.valid),
        .i_in_ready  (in_ch.ready),
        .i_in_data   (in_ch.data),
        .i_out_valid (out_ch.valid),
        .i_out_ready (out_ch.ready),
        .i_out_data  (out_ch.data),
        .o_errors    (errors),
        .o_results   (results)
    );

    initial i_clk = 1'b0;
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // receiver back-pressure, redrawn every cycle
    always @(posedge i_clk)
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic t_in_word mk(logic [2:0] cmd, logic [31:0] t, logic [2:0] kind,
                                    logic [15:0] ep, logic [2:0] row, logic [7:0] bin);
        t_in_word w;
        w.command     = cmd;
        w.event_time  = t;
        w.msg_kind    = kind;
        w.entry_point = ep;
        w.read_row    = row;
        w.read_bin    = bin;
        return w;
    endfunction

    // Present one word; valid stays high across back-to-back words, and only
    // drops when the sender decides to hold off before the next one.
    task automatic send_word(t_in_word w);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= w;
        do @(posedge i_clk); while (!(in_ch.valid && in_ch.ready));
        words_sent++;
    endtask

    // Drop valid, then wait for every result word so the block is idle.
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (results != words_sent)
            @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [1:0] idx, logic [31:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // One random word. Mostly well-formed begin/create/end traffic on a
    // rising clock, with reads, restarts and fully random noise mixed in.
    function automatic t_in_word random_word();
        int roll;
        logic [2:0] kind;
        logic [15:0] ep;
        roll = $urandom_range(99);
        kind = 3'($urandom_range(0, 7));
        ep = $urandom_range(1) ? 16'($urandom_range(0, 20)) : 16'($urandom);
        if (roll < 2)
            return mk(CMD_RESTART, now_t, kind, ep, 3'($urandom), 8'($urandom));
        if (roll < 4)
            return mk(3'($urandom), $urandom, kind, 16'($urandom), 3'($urandom),
                      8'($urandom));
        if (roll < 16)
            return mk(CMD_READ, now_t, kind, ep, 3'($urandom_range(0, 7)),
                      $urandom_range(1) ? 8'($urandom_range(0, 15)) : 8'($urandom));
        // time mostly moves forward; now and then it steps back a little
        if ($urandom_range(99) < 6)
            now_t = now_t - $urandom_range(0, step_t);
        else
            now_t = now_t + $urandom_range(0, step_t);
        if (roll < 50)
            return mk(CMD_CREATE, now_t, kind, ep, 3'($urandom), 8'($urandom));
        if (roll < 75)
            return mk(CMD_BEGIN, now_t, kind, ep, 3'($urandom), 8'($urandom));
        return mk(CMD_END, now_t, kind, ep, 3'($urandom), 8'($urandom));
    endfunction

    task automatic random_phase(int count);
        for (int n = 0; n < count; n++)
            send_word(random_word());
        drain();
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = CFG_INIT_WIDTH;
        i_cfg_data     = '0;
        in_ch.valid    = 1'b0;
        in_ch.data     = '0;
        out_ch.ready   = 1'b0;
        words_sent     = 0;
        cycles         = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        now_t          = '0;
        step_t         = 32'd3000;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ---- directed part, reset settings apart from the system entry bound
        cfg_write(CFG_SYS_ENTRY, 32'd10);
        // creation of several kinds, including ones that count no class
        send_word(mk(CMD_CREATE, 32'd0,    3'd0, 16'd0, 3'd0, 8'd0));
        send_word(mk(CMD_CREATE, 32'd500,  3'd1, 16'd0, 3'd0, 8'd0));
        send_word(mk(CMD_CREATE, 32'd1500, 3'd2, 16'd0, 3'd0, 8'd0));
        send_word(mk(CMD_CREATE, 32'd2500, 3'd6, 16'd0, 3'd0, 8'd0));
        send_word(mk(CMD_CREATE, 32'd2600, 3'd7, 16'd0, 3'd0, 8'd0));
        // system entry dropped, then a traced group entry spanning three bins
        send_word(mk(CMD_BEGIN, 32'd3000, KIND_GROUP, 16'd3,  3'd0, 8'd0));
        send_word(mk(CMD_BEGIN, 32'd3100, KIND_GROUP, 16'd10, 3'd0, 8'd0));
        send_word(mk(CMD_END,   32'd5600, KIND_GROUP, 16'd0,  3'd0, 8'd0));
        // end with nothing running
        send_word(mk(CMD_END,   32'd6000, 3'd0, 16'd0, 3'd0, 8'd0));
        // begin overwrites a running begin; time then steps back in the bin
        send_word(mk(CMD_BEGIN, 32'd7000, 3'd0, 16'd0, 3'd0, 8'd0));
        send_word(mk(CMD_BEGIN, 32'd7500, 3'd1, 16'd0, 3'd0, 8'd0));
        send_word(mk(CMD_END,   32'd7200, 3'd6, 16'd0, 3'd0, 8'd0));
        // end lands in a lower bin than its begin
        send_word(mk(CMD_BEGIN, 32'd8800, 3'd1, 16'hFFFF, 3'd0, 8'd0));
        send_word(mk(CMD_END,   32'd6100, 3'd1, 16'd0, 3'd0, 8'd0));
        for (int r = 0; r < 8; r++)
            send_word(mk(CMD_READ, 32'd0, 3'd0, 16'd0, 3'(r), 8'd3));
        send_word(mk(CMD_READ, 32'hFFFF_FFFF, 3'd7, 16'hFFFF, 3'd0, 8'd255));
        // far timestamp forces repeated width doubling and folding
        send_word(mk(CMD_CREATE, 32'hFFFF_FFFF, 3'd0, 16'd0, 3'd0, 8'd0));
        send_word(mk(CMD_READ,   32'd0, 3'd0, 16'd0, 3'd1, 8'd0));
        // unused commands only report the state
        send_word(mk(3'd5, 32'd1, 3'd0, 16'd0, 3'd0, 8'd0));
        send_word(mk(3'd7, 32'd2, 3'd0, 16'd0, 3'd0, 8'd0));
        send_word(mk(CMD_RESTART, 32'd0, 3'd0, 16'd0, 3'd0, 8'd0));
        drain();

        // ---- phase 1: default width, no idling
        random_phase(170);

        // ---- phase 2: zero width loads as one; sender idles
        cfg_write(CFG_INIT_WIDTH, 32'd0);
        cfg_write(CFG_TRACE_START, 32'd12345);
        cfg_write(CFG_SYS_ENTRY, 32'd0);
        send_idle_pct = 58;
        now_t  = 32'd12345;
        step_t = 32'd3;
        send_word(mk(CMD_RESTART, now_t, 3'd0, 16'd0, 3'd0, 8'd0));
        random_phase(170);

        // ---- phase 3: widest width, trace start at the top; receiver stalls
        cfg_write(CFG_INIT_WIDTH, 32'h7FFF_FFFF);
        cfg_write(CFG_TRACE_START, 32'hFFFF_FFFF);
        cfg_write(CFG_SYS_ENTRY, 32'hFFFF);
        send_idle_pct  = 0;
        recv_stall_pct = 58;
        step_t = 32'h0FFF_FFFF;
        send_word(mk(CMD_RESTART, now_t, 3'd0, 16'd0, 3'd0, 8'd0));
        random_phase(170);

        // ---- phase 4: odd width, shifted trace start while state carries over
        cfg_write(CFG_INIT_WIDTH, 32'd37);
        cfg_write(CFG_TRACE_START, 32'd5000);
        cfg_write(CFG_SYS_ENTRY, 32'd8);
        send_idle_pct  = 28;
        recv_stall_pct = 28;
        now_t  = 32'd5000;
        step_t = 32'd100;
        random_phase(170);

        repeat (200) @(posedge i_clk);
        if (errors == 0 && results == words_sent)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/atbeh_pkg.sv
hw/rtl/atbeh_stream_if.sv
hw/rtl/atbeh_ram.sv
hw/rtl/atbeh_div.sv
hw/rtl/atbeh_ctrl.sv
hw/rtl/atbeh_dp.sv
hw/rtl/adaptive_time_binned_event_histogram_top.sv
tb/atbeh_checker.sv
tb/tb.sv
